// ===== sv/tpc_pkg.sv =====
// Shared constants and stream payload layouts for the TCP port traffic counter.
`default_nettype none
package tpc_pkg;

  localparam int PORT_BITS         = 16;
  localparam int PACKET_COUNT_BITS = 32;
  localparam int BYTE_COUNT_BITS   = 48;

  localparam int FIXED_HEADER_BYTES = 20;
  localparam int WORD_BYTES         = 4;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SHORT_BASE = 2'd1;
  localparam logic [1:0] STATUS_SHORT_HDR  = 2'd2;

  // Request payload, first field in the lowest bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] destination_port;
    logic [15:0] source_port;
    logic [3:0]  data_offset_nibble;
    logic [15:0] header_offset;
    logic [15:0] packet_length;
  } in_item_t;

  // Result payload, first field in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [47:0] dst_bytes_received;
    logic [31:0] dst_packets_received;
    logic [47:0] src_bytes_sent;
    logic [31:0] src_packets_sent;
    logic [16:0] distinct_ports;
    logic [47:0] all_bytes;
    logic [31:0] all_packets;
    logic [15:0] payload_bytes;
    logic [5:0]  header_bytes;
    logic [1:0]  status;
  } out_item_t;

  localparam int IN_TDATA_BITS  = $bits(in_item_t);
  localparam int OUT_TDATA_BITS = $bits(out_item_t);

endpackage
`default_nettype wire

// ===== sv/tcp_port_traffic_counter.sv =====
// Top level of the TCP per-port traffic counter.
//
// Each request describes one TCP segment; the block checks that the frame holds the
// fixed and the declared header and, if it does, adds one packet and the payload bytes
// to the totals, to the out-counters of the source port and to the in-counters of the
// destination port, and returns one result with the updated counters. All per-port
// counters and the seen flag live in one RAM row per port. After acceptance a segment
// passes through the check, totals, source read-modify-write, destination read,
// destination read-modify-write and result load states before its result is valid;
// this order is set by the single RAM port pair and the one shared counter adder. The
// next request can be accepted in the cycle after the result is loaded, so a new
// segment is not taken before the result of the last one is loaded. A result waiting
// on the output does not stop the next request from being taken; that segment then
// waits in its result load until the output frees. After reset the RAM is cleared one
// row per cycle over all 2**PORT_BITS rows, and no request is accepted until it is done.
`default_nettype none
module tcp_port_traffic_counter #(
  parameter int PORT_BITS         = tpc_pkg::PORT_BITS,
  parameter int PACKET_COUNT_BITS = tpc_pkg::PACKET_COUNT_BITS,
  parameter int BYTE_COUNT_BITS   = tpc_pkg::BYTE_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // packet_length, header_offset, data_offset_nibble, source_port, destination_port
  input  logic [tpc_pkg::IN_TDATA_BITS-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status, header_bytes, payload_bytes, all_packets, all_bytes, distinct_ports,
  // src_packets_sent, src_bytes_sent, dst_packets_received, dst_bytes_received
  output logic [tpc_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  localparam int DEPTH   = 1 << PORT_BITS;
  localparam int PIN_LO  = 1;
  localparam int POUT_LO = PIN_LO + PACKET_COUNT_BITS;
  localparam int BIN_LO  = POUT_LO + PACKET_COUNT_BITS;
  localparam int BOUT_LO = BIN_LO + BYTE_COUNT_BITS;
  localparam int ROW_W   = BOUT_LO + BYTE_COUNT_BITS;

  typedef enum logic [2:0] {
    CLEAR, IDLE, CHECK, TOTAL, SRC_WR, DST_RD, DST_WR, DONE
  } state_t;

  state_t state;

  tpc_pkg::in_item_t  in_item;
  tpc_pkg::out_item_t out_item;

  logic [15:0]            packet_length;
  logic [15:0]            header_offset;
  logic [5:0]             header_bytes;
  logic [PORT_BITS-1:0]   src_row;
  logic [PORT_BITS-1:0]   dst_row;
  logic [PORT_BITS-1:0]   clear_addr;
  logic [1:0]             status;
  logic [15:0]            payload;
  logic                   accepted;

  logic [PACKET_COUNT_BITS-1:0] total_packets;
  logic [BYTE_COUNT_BITS-1:0]   total_bytes;
  logic [PORT_BITS:0]           distinct_count;
  logic [PACKET_COUNT_BITS-1:0] src_packets;
  logic [BYTE_COUNT_BITS-1:0]   src_bytes;
  logic [PACKET_COUNT_BITS-1:0] dst_packets;
  logic [BYTE_COUNT_BITS-1:0]   dst_bytes;

  logic [16:0] base_end;
  logic [16:0] hdr_end;
  logic [16:0] length_ext;

  logic                   ram_we;
  logic [PORT_BITS-1:0]   ram_waddr;
  logic [PORT_BITS-1:0]   ram_raddr;
  logic [ROW_W-1:0]       ram_wdata;
  logic [ROW_W-1:0]       ram_rdata;

  logic [PACKET_COUNT_BITS-1:0] unit_pkt;
  logic [BYTE_COUNT_BITS-1:0]   unit_bytes;
  logic [PACKET_COUNT_BITS-1:0] unit_pkt_sum;
  logic [BYTE_COUNT_BITS-1:0]   unit_byte_sum;

  assign in_item  = s_tdata;
  assign s_tready = (state == IDLE);
  assign m_tdata  = out_item;

  assign length_ext = {1'b0, packet_length};
  assign base_end   = {1'b0, header_offset} + 17'(tpc_pkg::FIXED_HEADER_BYTES);
  assign hdr_end    = {1'b0, header_offset} + 17'(header_bytes);

  tpc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_port_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tpc_counter_update #(
    .PACKET_COUNT_BITS(PACKET_COUNT_BITS),
    .BYTE_COUNT_BITS  (BYTE_COUNT_BITS)
  ) u_update (
    .apply     (accepted),
    .payload   (payload),
    .pkt_count (unit_pkt),
    .byte_count(unit_bytes),
    .pkt_sum   (unit_pkt_sum),
    .byte_sum  (unit_byte_sum)
  );

  // The shared adder serves the totals, then the source row, then the destination row.
  always_comb begin
    unit_pkt   = total_packets;
    unit_bytes = total_bytes;
    ram_we     = 1'b0;
    ram_waddr  = src_row;
    ram_raddr  = src_row;
    ram_wdata  = ram_rdata;
    unique case (state)
      CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      SRC_WR: begin
        unit_pkt   = ram_rdata[POUT_LO +: PACKET_COUNT_BITS];
        unit_bytes = ram_rdata[BOUT_LO +: BYTE_COUNT_BITS];
        ram_we     = accepted;
        ram_wdata[0] = ram_rdata[0] | accepted;
        ram_wdata[POUT_LO +: PACKET_COUNT_BITS] = unit_pkt_sum;
        ram_wdata[BOUT_LO +: BYTE_COUNT_BITS]   = unit_byte_sum;
      end
      DST_RD: begin
        ram_raddr = dst_row;
      end
      DST_WR: begin
        unit_pkt   = ram_rdata[PIN_LO +: PACKET_COUNT_BITS];
        unit_bytes = ram_rdata[BIN_LO +: BYTE_COUNT_BITS];
        ram_we     = accepted;
        ram_waddr  = dst_row;
        ram_raddr  = dst_row;
        ram_wdata[0] = ram_rdata[0] | accepted;
        ram_wdata[PIN_LO +: PACKET_COUNT_BITS] = unit_pkt_sum;
        ram_wdata[BIN_LO +: BYTE_COUNT_BITS]   = unit_byte_sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= CLEAR;
      clear_addr     <= '0;
      total_packets  <= '0;
      total_bytes    <= '0;
      distinct_count <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // A result load in DONE sets the valid itself.
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clear_addr <= clear_addr + PORT_BITS'(1);
          if (clear_addr == '1) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (s_tvalid) begin
            packet_length <= in_item.packet_length;
            header_offset <= in_item.header_offset;
            header_bytes  <= {in_item.data_offset_nibble, 2'b00};
            src_row       <= in_item.source_port[PORT_BITS-1:0];
            dst_row       <= in_item.destination_port[PORT_BITS-1:0];
            state         <= CHECK;
          end
        end
        CHECK: begin
          // The fixed-header check wins when both fail.
          if (length_ext < base_end) begin
            status   <= tpc_pkg::STATUS_SHORT_BASE;
            accepted <= 1'b0;
            payload  <= '0;
          end else if (length_ext < hdr_end) begin
            status   <= tpc_pkg::STATUS_SHORT_HDR;
            accepted <= 1'b0;
            payload  <= '0;
          end else begin
            status   <= tpc_pkg::STATUS_OK;
            accepted <= 1'b1;
            payload  <= 16'(length_ext - hdr_end);
          end
          state <= TOTAL;
        end
        TOTAL: begin
          total_packets <= unit_pkt_sum;
          total_bytes   <= unit_byte_sum;
          state         <= SRC_WR;
        end
        SRC_WR: begin
          src_packets <= unit_pkt_sum;
          src_bytes   <= unit_byte_sum;
          if (accepted && !ram_rdata[0]) begin
            distinct_count <= distinct_count + (PORT_BITS + 1)'(1);
          end
          state <= DST_RD;
        end
        DST_RD: begin
          state <= DST_WR;
        end
        DST_WR: begin
          dst_packets <= unit_pkt_sum;
          dst_bytes   <= unit_byte_sum;
          // When both ports are equal this row already carries the source update.
          if (accepted && !ram_rdata[0]) begin
            distinct_count <= distinct_count + (PORT_BITS + 1)'(1);
          end
          state <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            out_item.pad                  <= '0;
            out_item.status               <= status;
            out_item.header_bytes         <= header_bytes;
            out_item.payload_bytes        <= payload;
            out_item.all_packets          <= 32'(64'(total_packets));
            out_item.all_bytes            <= 48'(64'(total_bytes));
            out_item.distinct_ports       <= 17'(distinct_count);
            out_item.src_packets_sent     <= 32'(64'(src_packets));
            out_item.src_bytes_sent       <= 48'(64'(src_bytes));
            out_item.dst_packets_received <= 32'(64'(dst_packets));
            out_item.dst_bytes_received   <= 48'(64'(dst_bytes));
            m_tvalid                      <= 1'b1;
            state                         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/tpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/tpc_counter_update.sv =====
// Shared packet/byte counter adder used for the totals and both port entries.
`default_nettype none
module tpc_counter_update #(
  parameter int PACKET_COUNT_BITS = tpc_pkg::PACKET_COUNT_BITS,
  parameter int BYTE_COUNT_BITS   = tpc_pkg::BYTE_COUNT_BITS
) (
  input  logic                         apply,
  input  logic [15:0]                  payload,
  input  logic [PACKET_COUNT_BITS-1:0] pkt_count,
  input  logic [BYTE_COUNT_BITS-1:0]   byte_count,
  output logic [PACKET_COUNT_BITS-1:0] pkt_sum,
  output logic [BYTE_COUNT_BITS-1:0]   byte_sum
);

  // A rejected segment passes the counters through unchanged.
  always_comb begin
    if (apply) begin
      pkt_sum  = pkt_count + PACKET_COUNT_BITS'(1);
      byte_sum = byte_count + BYTE_COUNT_BITS'(payload);
    end else begin
      pkt_sum  = pkt_count;
      byte_sum = byte_count;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_tcp_port_traffic_counter.sv =====
// Self-checking testbench for the TCP per-port traffic counter, with stream driver and monitor.
`timescale 1ns / 100ps
module tb_tcp_port_traffic_counter;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TAIL_CYCLES    = 50;
  localparam int RANDOM_PER_PHASE = 500;

  localparam int PORT_W = tpc_pkg::PORT_BITS;
  localparam int PKT_W  = tpc_pkg::PACKET_COUNT_BITS;
  localparam int OCT_W  = tpc_pkg::BYTE_COUNT_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tpc_pkg::IN_TDATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tpc_pkg::OUT_TDATA_BITS-1:0] m_tdata;

  tcp_port_traffic_counter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Shadow copy of the per-port counters and totals.
  bit [PKT_W-1:0]  port_pkts_in  [0:(1<<PORT_W)-1];
  bit [PKT_W-1:0]  port_pkts_out [0:(1<<PORT_W)-1];
  bit [OCT_W-1:0]  port_octets_in  [0:(1<<PORT_W)-1];
  bit [OCT_W-1:0]  port_octets_out [0:(1<<PORT_W)-1];
  bit              port_was_seen [0:(1<<PORT_W)-1];
  bit [PKT_W-1:0]  sum_packets = '0;
  bit [OCT_W-1:0]  sum_octets = '0;
  bit [PORT_W:0]   seen_ports = '0;

  tpc_pkg::in_item_t  segment_queue [$];
  tpc_pkg::out_item_t expected_stats [$];

  bit [15:0] common_ports [8] = '{16'd0, 16'd22, 16'd53, 16'd80, 16'd443, 16'd1024,
                                  16'd8080, 16'd65535};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int segments_queued = 0;
  int segments_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d field %s: got %0h, expected %0h",
                             results_seen, name, got, want));
    end
  endtask

  function automatic tpc_pkg::out_item_t count_segment(tpc_pkg::in_item_t seg);
    tpc_pkg::out_item_t r;
    bit [5:0] hdr;
    bit [16:0] base_end;
    bit [16:0] hdr_end;
    bit [15:0] payload;
    bit [PORT_W-1:0] src;
    bit [PORT_W-1:0] dst;
    r = '0;
    payload = '0;
    hdr = {seg.data_offset_nibble, 2'b00};
    base_end = {1'b0, seg.header_offset} + 17'(tpc_pkg::FIXED_HEADER_BYTES);
    hdr_end = {1'b0, seg.header_offset} + {11'd0, hdr};
    src = seg.source_port[PORT_W-1:0];
    dst = seg.destination_port[PORT_W-1:0];
    if ({1'b0, seg.packet_length} < base_end) begin
      r.status = tpc_pkg::STATUS_SHORT_BASE;
    end else if ({1'b0, seg.packet_length} < hdr_end) begin
      r.status = tpc_pkg::STATUS_SHORT_HDR;
    end else begin
      r.status = tpc_pkg::STATUS_OK;
      payload = seg.packet_length - seg.header_offset - {10'd0, hdr};
      sum_packets = sum_packets + PKT_W'(1);
      sum_octets = sum_octets + OCT_W'(payload);
      // Source is marked first, so a port used on both sides counts once.
      if (!port_was_seen[src]) begin
        port_was_seen[src] = 1'b1;
        seen_ports = seen_ports + (PORT_W + 1)'(1);
      end
      if (!port_was_seen[dst]) begin
        port_was_seen[dst] = 1'b1;
        seen_ports = seen_ports + (PORT_W + 1)'(1);
      end
      port_pkts_out[src] = port_pkts_out[src] + PKT_W'(1);
      port_pkts_in[dst] = port_pkts_in[dst] + PKT_W'(1);
      port_octets_out[src] = port_octets_out[src] + OCT_W'(payload);
      port_octets_in[dst] = port_octets_in[dst] + OCT_W'(payload);
    end
    r.header_bytes = hdr;
    r.payload_bytes = payload;
    r.all_packets = 32'(sum_packets);
    r.all_bytes = 48'(sum_octets);
    r.distinct_ports = 17'(seen_ports);
    r.src_packets_sent = 32'(port_pkts_out[src]);
    r.src_bytes_sent = 48'(port_octets_out[src]);
    r.dst_packets_received = 32'(port_pkts_in[dst]);
    r.dst_bytes_received = 48'(port_octets_in[dst]);
    return r;
  endfunction

  task automatic queue_segment(int len, int off, int nib, int src, int dst);
    tpc_pkg::in_item_t seg;
    seg = '0;
    seg.packet_length = 16'(len);
    seg.header_offset = 16'(off);
    seg.data_offset_nibble = 4'(nib);
    seg.source_port = 16'(src);
    seg.destination_port = 16'(dst);
    segment_queue.push_back(seg);
    segments_queued++;
  endtask

  function automatic int pick_port();
    if ($urandom_range(99) < 50) begin
      return common_ports[$urandom_range(7)];
    end
    return $urandom_range(65535);
  endfunction

  task automatic queue_random_segment();
    int kind;
    int nib;
    int hdr;
    int need;
    int off;
    int len;
    int src;
    int dst;
    kind = $urandom_range(99);
    nib = $urandom_range(15);
    src = pick_port();
    dst = ($urandom_range(9) == 0) ? src : pick_port();
    if (kind < 70) begin
      // Well-formed segment, mostly realistic offsets and payloads.
      hdr = nib * tpc_pkg::WORD_BYTES;
      need = (hdr > tpc_pkg::FIXED_HEADER_BYTES) ? hdr : tpc_pkg::FIXED_HEADER_BYTES;
      if ($urandom_range(1)) off = $urandom_range(54, 14);
      else off = $urandom_range(65535 - need);
      if ($urandom_range(1) && off + need <= 65535 - 1500) len = off + need + $urandom_range(1500);
      else len = $urandom_range(65535, off + need);
    end else if (kind < 80) begin
      // Frame ends before the fixed header does.
      off = $urandom_range(65535);
      len = $urandom_range((off + tpc_pkg::FIXED_HEADER_BYTES - 1 > 65535) ? 65535
                           : off + tpc_pkg::FIXED_HEADER_BYTES - 1);
    end else if (kind < 90) begin
      // Fixed header fits, declared header does not.
      nib = $urandom_range(15, 6);
      hdr = nib * tpc_pkg::WORD_BYTES;
      off = $urandom_range(65536 - hdr);
      len = $urandom_range(off + hdr - 1, off + tpc_pkg::FIXED_HEADER_BYTES);
    end else begin
      off = $urandom_range(65535);
      len = $urandom_range(65535);
    end
    queue_segment(len, off, nib, src, dst);
  endtask

  // Request driver: holds tdata until accepted, then may insert idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (segment_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= segment_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    tpc_pkg::out_item_t got;
    tpc_pkg::out_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (s_tvalid && s_tready) begin
        expected_stats.push_back(count_segment(tpc_pkg::in_item_t'(s_tdata)));
        segments_taken++;
      end
      if (m_tvalid && m_tready) begin
        got = tpc_pkg::out_item_t'(m_tdata);
        if (expected_stats.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_stats.pop_front();
          check_field("status", 64'(got.status), 64'(want.status));
          check_field("header_bytes", 64'(got.header_bytes), 64'(want.header_bytes));
          check_field("payload_bytes", 64'(got.payload_bytes), 64'(want.payload_bytes));
          check_field("all_packets", 64'(got.all_packets), 64'(want.all_packets));
          check_field("all_bytes", 64'(got.all_bytes), 64'(want.all_bytes));
          check_field("distinct_ports", 64'(got.distinct_ports), 64'(want.distinct_ports));
          check_field("src_packets_sent", 64'(got.src_packets_sent),
                      64'(want.src_packets_sent));
          check_field("src_bytes_sent", 64'(got.src_bytes_sent), 64'(want.src_bytes_sent));
          check_field("dst_packets_received", 64'(got.dst_packets_received),
                      64'(want.dst_packets_received));
          check_field("dst_bytes_received", 64'(got.dst_bytes_received),
                      64'(want.dst_bytes_received));
        end
        results_seen++;
      end
    end
  end

  // Watchdog: the clearing pass after reset is the longest quiet stretch.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: field extremes, each rejection and the header corner cases.
    queue_segment(0, 0, 0, 0, 0);
    queue_segment(19, 0, 5, 1, 2);
    queue_segment(20, 0, 5, 1, 2);
    queue_segment(20, 0, 0, 3, 4);
    queue_segment(10, 0, 15, 5, 6);
    queue_segment(59, 0, 15, 7, 8);
    queue_segment(60, 0, 15, 7, 8);
    queue_segment(65535, 0, 5, 0, 65535);
    queue_segment(65535, 0, 15, 65535, 0);
    queue_segment(65535, 65535, 15, 80, 80);
    queue_segment(65535, 65515, 0, 443, 443);
    queue_segment(65535, 65516, 0, 443, 443);
    queue_segment(65535, 65475, 15, 22, 53);
    queue_segment(65535, 65476, 15, 22, 53);
    queue_segment(1514, 34, 8, 8080, 80);
    queue_segment(1514, 34, 8, 80, 8080);
    queue_segment(54, 34, 5, 1024, 443);
    queue_segment(0, 65535, 0, 65535, 65535);
    queue_segment(65535, 0, 1, 32768, 32767);
    queue_segment(40000, 20000, 4, 43690, 21845);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 32;
          recv_stall_pct = 32;
        end
      endcase
      repeat (RANDOM_PER_PHASE) queue_random_segment();
      while (segment_queue.size() != 0) @(posedge clk);
    end

    while (segments_taken != segments_queued || expected_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
